### hw/rtl/oers_pkg.sv
`timescale 1ns / 1ps

package oers_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TIME     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIMEOUT = 8'd1;

	localparam logic [CFG_W-1:0] REVERSE_TIME_RST     = 16'd3000;
	localparam logic [CFG_W-1:0] RECOVERY_TIMEOUT_RST = 16'd5000;

	typedef enum logic [2:0] {
		REQ_BEGIN    = 3'd0,
		REQ_TICK     = 3'd1,
		REQ_OBSTACLE = 3'd2,
		REQ_LIFT     = 3'd3,
		REQ_UNDERVOLT = 3'd4,
		REQ_IMU_TILT = 3'd5,
		REQ_IMU_ERR  = 3'd6,
		REQ_KIDNAP   = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		DRV_NONE      = 3'd0,
		DRV_STOP      = 3'd1,
		DRV_SLOW_FWD  = 3'd2,
		DRV_REV       = 3'd3,
		DRV_REV_RIGHT = 3'd4,
		DRV_REV_LEFT  = 3'd5
	} drv_t;

	typedef enum logic [2:0] {
		MODE_STAY   = 3'd0,
		MODE_ERROR  = 3'd1,
		MODE_IDLE   = 3'd2,
		MODE_RESUME = 3'd3,
		MODE_GPS    = 3'd4
	} mode_t;

	typedef struct packed {
		logic kidnap_active;
		logic has_next_op;
		logic lift_sensor;
		logic inside_perimeter;
		logic bumper_right;
		logic bumper_left;
		logic [TIME_W-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic  in_recovery;
		logic  request_replan;
		logic  record_obstacle;
		mode_t next_mode;
		drv_t  drive_cmd;
	} out_word_t;

endpackage

### hw/rtl/obstacle_escape_reverse_sequencer.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: now_ms, bumpers, sensors
// m_      | out | m_tvalid/m_tready  | m_tdata: drive_cmd, next_mode, flags
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; each word passes through the
// input register, then decode and state update into the result register.
// The sequencer state commits when a word moves from the input register to the
// result register, so back-to-back words see each other's updates.
// A stalled output holds both stages; cfg_ready is always high.
// Reset clears the sequencer state and loads the default timings.
module obstacle_escape_reverse_sequencer import oers_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] now_ms, [32] bumper_left, [33] bumper_right, [34] inside_perimeter,
	// [35] lift_sensor, [36] has_next_op, [37] kidnap_active, [39:38] zero
	input  logic [39:0]          s_tdata,
	// [2:0] req_type
	input  logic [2:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [2:0] drive_cmd, [5:3] next_mode, [6] record_obstacle, [7] request_replan,
	// [8] in_recovery, [15:9] zero
	output logic [15:0]          m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] reverse_time_q, recovery_timeout_q;

	logic active_q, recovering_q, hit_left_q, hit_right_q;
	logic [TIME_W-1:0] deadline_q, rec_start_q;

	logic      valid_s1, valid_s2;
	req_t      req_s1;
	in_word_t  in_s1;
	out_word_t res_s2;

	logic adv2, adv1;

	logic active_n, recovering_n, hit_left_n, hit_right_n;
	logic [TIME_W-1:0] deadline_n, rec_start_n;
	logic [TIME_W-1:0] armed, since_deadline, since_start;
	out_word_t res_n;

	assign cfg_ready = 1'b1;
	assign adv2 = !valid_s2 || m_tready;
	assign adv1 = !valid_s1 || adv2;
	assign s_tready = adv1;

	assign armed = in_s1.now_ms + {{(TIME_W-CFG_W){1'b0}}, reverse_time_q};
	assign since_deadline = in_s1.now_ms - deadline_q;
	assign since_start = in_s1.now_ms - rec_start_q;

	always_comb begin
		logic  in_rec_keep;
		logic  quiet;
		drv_t  drv;
		mode_t mode;
		logic  rec, replan;
		in_rec_keep = 1'b0;
		quiet = 1'b0;
		drv = DRV_NONE;
		mode = MODE_STAY;
		rec = 1'b0;
		replan = 1'b0;
		active_n = active_q;
		recovering_n = recovering_q;
		hit_left_n = hit_left_q;
		hit_right_n = hit_right_q;
		deadline_n = deadline_q;
		rec_start_n = rec_start_q;

		if (req_s1 == REQ_BEGIN) begin
			active_n = 1'b1;
			hit_left_n = in_s1.bumper_left;
			hit_right_n = in_s1.bumper_right;
			deadline_n = armed;
			recovering_n = 1'b0;
			rec_start_n = '0;
			rec = 1'b1;
		end else if (active_q) begin
			unique case (req_s1)
				REQ_TICK: begin
					if (recovering_q) begin
						if (in_s1.inside_perimeter) begin
							recovering_n = 1'b0;
							deadline_n = armed;
						end else if (since_start > {{(TIME_W-CFG_W){1'b0}}, recovery_timeout_q}) begin
							drv = DRV_STOP;
							mode = MODE_ERROR;
						end else begin
							drv = DRV_SLOW_FWD;
						end
					end else if (!in_s1.inside_perimeter) begin
						recovering_n = 1'b1;
						rec_start_n = in_s1.now_ms;
						drv = DRV_STOP;
					end else if (!since_deadline[TIME_W-1]) begin
						deadline_n = '0;
						drv = DRV_STOP;
						priority if (in_s1.lift_sensor) begin
							mode = MODE_ERROR;
						end else if (in_s1.has_next_op) begin
							mode = MODE_RESUME;
							replan = 1'b1;
						end else begin
							mode = MODE_IDLE;
						end
					end else if (hit_left_q && !hit_right_q) begin
						drv = DRV_REV_RIGHT;
					end else if (hit_right_q && !hit_left_q) begin
						drv = DRV_REV_LEFT;
					end else begin
						drv = DRV_REV;
					end
				end
				REQ_OBSTACLE: begin
					deadline_n = armed;
					rec = 1'b1;
				end
				REQ_LIFT, REQ_UNDERVOLT: begin
					drv = DRV_STOP;
					mode = MODE_ERROR;
				end
				REQ_IMU_TILT, REQ_IMU_ERR: begin
					mode = MODE_ERROR;
				end
				REQ_KIDNAP: begin
					if (in_s1.kidnap_active) begin
						drv = DRV_STOP;
						mode = MODE_GPS;
					end else begin
						// inactive kidnap gives an all-zero word
						quiet = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// any transition drops the sequence until the next begin
		if (mode != MODE_STAY) begin
			active_n = 1'b0;
		end
		in_rec_keep = active_n && recovering_n && !quiet;

		res_n.drive_cmd = drv;
		res_n.next_mode = mode;
		res_n.record_obstacle = rec;
		res_n.request_replan = replan;
		res_n.in_recovery = in_rec_keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_time_q <= REVERSE_TIME_RST;
			recovery_timeout_q <= RECOVERY_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_REVERSE_TIME) begin
				reverse_time_q <= cfg_data;
			end else if (cfg_index == CFG_RECOVERY_TIMEOUT) begin
				recovery_timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			active_q <= 1'b0;
			recovering_q <= 1'b0;
			hit_left_q <= 1'b0;
			hit_right_q <= 1'b0;
			deadline_q <= '0;
			rec_start_q <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			// commit state as the word moves into the result register
			if (valid_s1 && adv2) begin
				active_q <= active_n;
				recovering_q <= recovering_n;
				hit_left_q <= hit_left_n;
				hit_right_q <= hit_right_n;
				deadline_q <= deadline_n;
				rec_start_q <= rec_start_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			req_s1 <= req_t'(s_tuser);
			in_s1 <= in_word_t'(s_tdata[37:0]);
		end
		if (adv2 && valid_s1) begin
			res_s2 <= res_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {7'd0, res_s2};

endmodule

### hw/rtl/oers_checker.sv
`timescale 1ns / 1ps

module oers_checker import oers_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	out_word_t w;
	assign w = out_word_t'(m_tdata[8:0]);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_replan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && w.request_replan |-> w.next_mode == MODE_RESUME && w.drive_cmd == DRV_STOP)
		else $error("replan without resume");

	// a word during recovery stays in mode and stops, creeps forward, or logs an obstacle with no command
	a_recovery: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && w.in_recovery |-> w.next_mode == MODE_STAY &&
			(w.drive_cmd == DRV_STOP || w.drive_cmd == DRV_SLOW_FWD ||
			(w.drive_cmd == DRV_NONE && w.record_obstacle)))
		else $error("recovery flag with bad command");

	a_record: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && w.record_obstacle |-> w.drive_cmd == DRV_NONE &&
			w.next_mode == MODE_STAY)
		else $error("obstacle log with a command");

endmodule

bind obstacle_escape_reverse_sequencer oers_checker u_oers_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
